[rtl/knn_pkg.sv]
package knn_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int LW_W      = 11;
    localparam int PIX_W     = 24;
    localparam int NB_COUNT  = 8;
    localparam int DIST_W    = 18;
    localparam int SUM_W     = 17;
    localparam int DIV_W     = 9;
    localparam int QUO_W     = 9;

    localparam logic [1:0] REG_COUNT  = 2'd0;
    localparam logic [1:0] REG_WEIGHT = 2'd1;
    localparam logic [1:0] REG_MODE   = 2'd2;
    localparam logic [1:0] REG_WIDTH  = 2'd3;

    typedef logic [PIX_W-1:0] pix_t;

    // One neighbour travelling down the selection chain.
    typedef struct packed {
        logic              valid;
        logic [DIST_W-1:0] dsq;
        logic [2:0]        idx;
        pix_t              pix;
    } cand_t;

    function automatic logic [7:0] chan(input pix_t p, input int ch);
        chan = p[PIX_W-1-8*ch -: 8];
    endfunction

    function automatic logic [15:0] sqd(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] d;
        d = (a > b) ? a - b : b - a;
        sqd = {8'd0, d} * {8'd0, d};
    endfunction

endpackage

[rtl/knn_ram.sv]
module knn_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[rtl/knn_cell.sv]
// One cell of the sorting chain: keep the nearest candidate seen so far, pass the other on.
module knn_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                clear,
    input  knn_pkg::cand_t      cin,
    output knn_pkg::cand_t      cout,
    output knn_pkg::cand_t      held
);
    import knn_pkg::*;

    cand_t keep_reg;
    cand_t keep_next;
    cand_t pass_reg;
    cand_t pass_next;

    always_comb
    begin
        keep_next = keep_reg;
        pass_next = cin;
        if (clear)
        begin
            keep_next = '0;
            pass_next = '0;
        end
        else if (cin.valid)
        begin
            // equal distances go to the lower neighbour index
            if (!keep_reg.valid || cin.dsq < keep_reg.dsq
                || (cin.dsq == keep_reg.dsq && cin.idx < keep_reg.idx))
            begin
                keep_next = cin;
                pass_next = keep_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_reg <= '0;
            pass_reg <= '0;
        end
        else
        begin
            keep_reg <= keep_next;
            pass_reg <= pass_next;
        end
    end

    assign cout = pass_reg;
    assign held = keep_reg;
endmodule

[rtl/knn_div.sv]
// Restoring divider, one quotient bit per cycle.
module knn_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [knn_pkg::SUM_W-1:0]  dividend,
    input  logic [knn_pkg::DIV_W-1:0]  divisor,
    output logic                       done,
    output logic [7:0]                 quotient
);
    import knn_pkg::*;

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0] quo_reg, quo_next;
    logic [SUM_W:0]   rem_reg, rem_next;
    logic [DIV_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [SUM_W:0]   trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[SUM_W-1:0], quo_reg[SUM_W-1]};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = CNT_W'(SUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[SUM_W-2:0], 1'b0};
            if (trial >= (SUM_W+1)'(dvs_reg))
            begin
                rem_next    = trial - (SUM_W+1)'(dvs_reg);
                quo_next[0] = 1'b1;
            end
            else
            begin
                rem_next = trial;
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg[7:0];
endmodule

[rtl/knn_line_preserving_smoother_top.sv]
// KNN line-preserving 3x3 smoother.
// Input channel (valid/stall): one word per pixel in raster order, command 0
// carries a pixel, command 1 is a flush word that repeats the last row so the
// bottom row gets finished. Output channel (valid/stall): smoothed pixels of
// the row above, with out_column and last_of_run on the final word caused by
// each input word. A word gives 0, 1 or 2 results.
// Processing: an input word is read from the line stores and the window is
// updated, then the 8 neighbours are fed through a chain of 8 cells and left
// to settle, the sums are registered, and one shared bit-serial divider
// handles the channels in turn (only the first one in gray mode). A second
// result repeats the load, sort, sum and divide steps. A word with no result
// goes back to idle after the window update. One word is in work at a time
// and stall is high while it is.
// When the receiver stalls, the result word holds in the output register; the
// next word may still be taken, but its own result waits until that one goes.
// Reset clears counters, row count, window and configuration to their defaults
// (k=3, weight 1, gray, 640 pixels). The line stores are not cleared: they are
// always written before being read within an image.
// Write configuration only while no word is in work.
module knn_line_preserving_smoother_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       valid,
    output logic                       stall,
    input  logic                       command,
    input  logic [7:0]                 red_or_gray,
    input  logic [7:0]                 green_in,
    input  logic [7:0]                 blue_in,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [7:0]                 out_red_or_gray,
    output logic [7:0]                 out_green,
    output logic [7:0]                 out_blue,
    output logic [knn_pkg::COL_W-1:0]  out_column,
    output logic                       last_of_run,
    input  logic                       cfg_we,
    input  logic [1:0]                 cfg_index,
    input  logic [knn_pkg::LW_W-1:0]   cfg_data
);
    import knn_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_UPD, S_LOAD, S_SORT, S_SUM, S_DIV, S_WAIT, S_OUT
    } state_t;

    state_t state_reg;

    // configuration
    logic [3:0]      k_reg;
    logic [7:0]      wt_reg;
    logic            rgb_reg;
    logic [LW_W-1:0] lw_reg;

    // item state
    logic [COL_W-1:0] col_reg;
    logic [1:0]       rows_reg;
    pix_t             win_reg [3][3];
    logic             flush_reg;
    pix_t             pix_reg;
    logic [COL_W-1:0] x_reg;
    logic             last_reg;
    logic             second_reg;  // second result (last column) in work
    logic             has_first_reg;

    // result window and sort
    pix_t             w_reg [3][3];
    logic [3:0]       feed_reg;
    logic [SUM_W-1:0] sum_reg [3];
    logic [DIV_W-1:0] div_reg;
    logic [1:0]       dch_reg;
    logic [7:0]       res_reg [3];

    // output register
    logic             ov_reg;
    logic [7:0]       or_reg, og_reg, ob_reg;
    logic [COL_W-1:0] oc_reg;
    logic             ol_reg;

    // effective width and count
    logic [LW_W-1:0]  wdt;
    logic [COL_W-1:0] xe;
    logic [3:0]       keff;

    always_comb
    begin
        wdt = lw_reg;
        if (wdt == '0)
        begin
            wdt = LW_W'(1);
        end
        if (wdt > LW_W'(MAX_WIDTH))
        begin
            wdt = LW_W'(MAX_WIDTH);
        end
        xe = col_reg;
        if (LW_W'(col_reg) >= wdt)
        begin
            xe = COL_W'(wdt - 1'b1);
        end
        keff = k_reg;
        if (keff == 4'd0)
        begin
            keff = 4'd1;
        end
        if (keff > 4'd9)
        begin
            keff = 4'd9;
        end
    end

    // line stores
    logic older_we, mid_we;
    pix_t older_rd, mid_rd;

    knn_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_older (
        .clk(clk), .we(older_we), .waddr(x_reg), .wdata(mid_rd),
        .raddr(xe), .rdata(older_rd)
    );
    knn_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
        .clk(clk), .we(mid_we), .waddr(x_reg), .wdata(flush_reg ? mid_rd : pix_reg),
        .raddr(xe), .rdata(mid_rd)
    );

    assign mid_we   = (state_reg == S_UPD);
    assign older_we = (state_reg == S_UPD) && (rows_reg != 2'd0);

    // neighbour feed into the cell chain
    pix_t  nb [NB_COUNT];
    cand_t feed;
    cand_t link [NB_COUNT+1];
    cand_t held [NB_COUNT];
    logic  chain_clear;
    pix_t  c;
    pix_t  fp;
    logic [DIST_W-1:0] fd;

    always_comb
    begin
        c     = w_reg[1][1];
        nb[0] = w_reg[0][0];
        nb[1] = w_reg[0][1];
        nb[2] = w_reg[0][2];
        nb[3] = w_reg[1][0];
        nb[4] = w_reg[1][2];
        nb[5] = w_reg[2][0];
        nb[6] = w_reg[2][1];
        nb[7] = w_reg[2][2];
        fp    = nb[feed_reg[2:0]];
        fd    = DIST_W'(sqd(chan(c, 0), chan(fp, 0)));
        if (rgb_reg)
        begin
            fd = fd + DIST_W'(sqd(chan(c, 1), chan(fp, 1)))
                    + DIST_W'(sqd(chan(c, 2), chan(fp, 2)));
        end
        feed.valid = (state_reg == S_SORT) && !feed_reg[3];
        feed.dsq   = fd;
        feed.idx   = feed_reg[2:0];
        feed.pix   = fp;
    end

    assign chain_clear = (state_reg == S_LOAD);
    assign link[0]     = feed;

    for (genvar g = 0; g < NB_COUNT; g++)
    begin : g_cell
        knn_cell u_cell (
            .clk(clk), .rst_n(rst_n), .clear(chain_clear),
            .cin(link[g]), .cout(link[g+1]), .held(held[g])
        );
    end

    // sums of centre*weight plus the k-1 nearest
    logic [SUM_W-1:0] sum_next [3];

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            sum_next[ch] = SUM_W'(chan(c, ch)) * SUM_W'(wt_reg);
            for (int i = 0; i < NB_COUNT; i++)
            begin
                if (i + 1 < int'(keff))
                begin
                    sum_next[ch] = sum_next[ch] + SUM_W'(chan(held[i].pix, ch));
                end
            end
        end
    end

    // shared divider, one channel after the other
    logic       div_start;
    logic       div_done;
    logic [7:0] div_q;

    knn_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .dividend(sum_reg[dch_reg]), .divisor(div_reg),
        .done(div_done), .quotient(div_q)
    );

    assign div_start = (state_reg == S_DIV);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_reg         <= 4'd3;
            wt_reg        <= 8'd1;
            rgb_reg       <= 1'b0;
            lw_reg        <= LW_W'(640);
            col_reg       <= '0;
            rows_reg      <= '0;
            ov_reg        <= 1'b0;
            second_reg    <= 1'b0;
            has_first_reg <= 1'b0;
            feed_reg      <= '0;
            dch_reg       <= '0;
            for (int r = 0; r < 3; r++)
            begin
                for (int q = 0; q < 3; q++)
                begin
                    win_reg[r][q] <= '0;
                end
            end
        end
        else
        begin
            // drop the taken word unless a new one replaces it below
            if (ov_reg && !out_stall && state_reg != S_OUT)
            begin
                ov_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_COUNT:  k_reg   <= cfg_data[3:0];
                    REG_WEIGHT: wt_reg  <= cfg_data[7:0];
                    REG_MODE:   rgb_reg <= cfg_data[0];
                    REG_WIDTH:  lw_reg  <= cfg_data;
                    default:    k_reg   <= k_reg;
                endcase
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (valid)
                    begin
                        flush_reg <= command;
                        pix_reg   <= {red_or_gray, green_in, blue_in};
                        x_reg     <= xe;
                        last_reg  <= (LW_W'(xe) == wdt - 1'b1);
                        if (!(command && rows_reg == 2'd0))
                        begin
                            state_reg <= S_READ;
                        end
                    end
                end
                S_READ:
                begin
                    state_reg <= S_UPD;
                end
                S_UPD:
                begin
                    // shift window, bring in the new column
                    for (int r = 0; r < 3; r++)
                    begin
                        win_reg[r][0] <= win_reg[r][1];
                        win_reg[r][1] <= win_reg[r][2];
                    end
                    win_reg[0][2] <= (rows_reg >= 2'd2) ? older_rd : mid_rd;
                    win_reg[1][2] <= mid_rd;
                    win_reg[2][2] <= flush_reg ? mid_rd : pix_reg;
                    if (last_reg)
                    begin
                        col_reg <= '0;
                        if (flush_reg)
                        begin
                            rows_reg <= '0;
                        end
                        else if (rows_reg < 2'd2)
                        begin
                            rows_reg <= rows_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        col_reg <= x_reg + 1'b1;
                    end
                    has_first_reg <= (rows_reg != 2'd0) && (x_reg != '0);
                    second_reg    <= (rows_reg != 2'd0) && last_reg;
                    if (rows_reg == 2'd0 || (x_reg == '0 && !last_reg))
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    for (int r = 0; r < 3; r++)
                    begin
                        if (has_first_reg)
                        begin
                            w_reg[r][0] <= (x_reg == COL_W'(1)) ? win_reg[r][1]
                                                                 : win_reg[r][0];
                            w_reg[r][1] <= win_reg[r][1];
                            w_reg[r][2] <= win_reg[r][2];
                        end
                        else
                        begin
                            w_reg[r][0] <= (x_reg == '0) ? win_reg[r][2]
                                                         : win_reg[r][1];
                            w_reg[r][1] <= win_reg[r][2];
                            w_reg[r][2] <= win_reg[r][2];
                        end
                    end
                    feed_reg  <= '0;
                    state_reg <= S_SORT;
                end
                S_SORT:
                begin
                    // feed 8 neighbours, then let the chain settle
                    feed_reg <= feed_reg + 1'b1;
                    if (feed_reg == 4'd15)
                    begin
                        state_reg <= S_SUM;
                    end
                end
                S_SUM:
                begin
                    for (int ch = 0; ch < 3; ch++)
                    begin
                        sum_reg[ch] <= sum_next[ch];
                    end
                    div_reg   <= DIV_W'(wt_reg) + DIV_W'(keff) - 1'b1;
                    dch_reg   <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (div_done)
                    begin
                        res_reg[dch_reg] <= (div_reg == '0)
                                            ? chan(w_reg[1][1], int'(dch_reg)) : div_q;
                        if (dch_reg == 2'd2 || !rgb_reg)
                        begin
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            dch_reg   <= dch_reg + 1'b1;
                            state_reg <= S_DIV;
                        end
                    end
                end
                S_OUT:
                begin
                    if (!ov_reg || !out_stall)
                    begin
                        ov_reg <= 1'b1;
                        or_reg <= res_reg[0];
                        og_reg <= rgb_reg ? res_reg[1] : 8'd0;
                        ob_reg <= rgb_reg ? res_reg[2] : 8'd0;
                        if (has_first_reg)
                        begin
                            oc_reg        <= x_reg - 1'b1;
                            ol_reg        <= !second_reg;
                            has_first_reg <= 1'b0;
                            state_reg     <= second_reg ? S_LOAD : S_IDLE;
                        end
                        else
                        begin
                            oc_reg     <= x_reg;
                            ol_reg     <= 1'b1;
                            second_reg <= 1'b0;
                            state_reg  <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign stall           = (state_reg != S_IDLE);
    assign out_valid       = ov_reg;
    assign out_red_or_gray = or_reg;
    assign out_green       = og_reg;
    assign out_blue        = ob_reg;
    assign out_column      = oc_reg;
    assign last_of_run     = ol_reg;
endmodule
